>>> hdl/nvc_pkg.sv
// Package for the NV21 to RGB32 converter.
// Holds the payload structs, command and sequencer codes, the fixed widths and
// the color conversion constants. No dependencies.
package nvc_pkg;

   // Fixed widths of the ports and of the frame position.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int COORD_W     = 10;
   localparam int POS_W       = 21;

   // Depths of the command queue and of the result queue.
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 8;

   // Cycles after a size write before the derived frame sizes are valid.
   localparam int SETTLE_W      = 2;
   localparam int SETTLE_CYCLES = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   // Result kinds.
   localparam logic RESULT_PIXEL  = 1'b0;
   localparam logic RESULT_NOTICE = 1'b1;

   // Conversion arithmetic: accumulator width and BT.601 integer coefficients.
   localparam int ACC_W = 20;
   localparam logic signed [ACC_W-1:0] COEF_Y     = 20'sd298;
   localparam logic signed [ACC_W-1:0] COEF_RV    = 20'sd409;
   localparam logic signed [ACC_W-1:0] COEF_GU    = 20'sd100;
   localparam logic signed [ACC_W-1:0] COEF_GV    = 20'sd208;
   localparam logic signed [ACC_W-1:0] COEF_BU    = 20'sd516;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = 20'sd128;
   localparam logic signed [9:0]       LUMA_BIAS   = 10'sd16;
   localparam logic signed [9:0]       CHROMA_BIAS = 10'sd128;
   localparam logic [7:0]              COLOR_MAX   = 8'hFF;

   // Work codes passed from the front part to the back part.
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LUMA,
      CMD_BLOCK
   } cmd_op_type;

   // Back part sequencer states.
   typedef enum logic {
      SEQ_WORK,
      SEQ_NOTICE
   } seq_state_type;

   // One input byte.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   // One result item.
   typedef struct packed {
      logic               result_kind;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [7:0]         pixel_red;
      logic [7:0]         pixel_green;
      logic [7:0]         pixel_blue;
      logic               last_of_run;
   } rsp_type;

   // Shift right by eight with floor, then clamp to 0..255.
   function automatic logic [7:0] clamp_pixel(input logic signed [ACC_W-1:0] acc);
      logic [7:0] result;
      if (acc[ACC_W-1]) begin
         result = 8'd0;
      end else if (acc[ACC_W-1:8] > (ACC_W-8)'(COLOR_MAX)) begin
         result = COLOR_MAX;
      end else begin
         result = acc[15:8];
      end
      return result;
   endfunction

endpackage

>>> hdl/nvc_cmd_queue.sv
// Short queue of work commands between the front and back parts of the
// NV21 converter. Depends on nothing; the command layout is opaque here.
module nvc_cmd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/nvc_front.sv
// Front part of the NV21 converter: size registers, frame position tracking
// and classification of each input byte into a work command. Uses nvc_pkg.
module nvc_front
   import nvc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int WW    = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + 1),
   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
   localparam int CMD_W = $bits(cmd_op_type) + 17 + WW + HW + 2 * AW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   output logic                   cmd_push,
   output logic [CMD_W-1:0]       cmd_data,
   input  logic                   cmd_full
);

   localparam int TW  = AW + 1;
   localparam int PSW = POS_W + 1;
   localparam int CW  = (PSW > TW) ? PSW : TW;
   localparam int WCW = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int HCW = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;

   typedef struct packed {
      cmd_op_type      op;
      logic            notice;
      logic [7:0]      data;
      logic [7:0]      v_byte;
      logic [WW-1:0]   x0;
      logic [HW-1:0]   y0;
      logic [AW-1:0]   top_addr;
      logic [AW-1:0]   bot_addr;
   } cmd_type;

   logic [CSR_DATA_W-1:0] frame_width_ff, frame_width_in;
   logic [CSR_DATA_W-1:0] frame_height_ff, frame_height_in;
   logic [SETTLE_W-1:0]   settle_ff, settle_in;
   logic [WW-1:0]         eff_w_ff, eff_w_in;
   logic [HW-1:0]         eff_h_ff, eff_h_in;
   logic [TW-1:0]         luma_n_ff, luma_n_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [7:0]            v_latch_ff, v_latch_in;
   logic [WW-1:0]         x0_ff, x0_in;
   logic [HW-1:0]         y0_ff, y0_in;
   logic [TW-1:0]         base_ff, base_in;

   logic [WCW-1:0] width_c, width_lim, width_sel;
   logic [HCW-1:0] height_c, height_lim, height_sel;
   logic [WW-1:0]  width_trim;
   logic [HW-1:0]  height_trim;

   logic          accept, csr_hit, size_zero;
   logic          in_luma, in_chroma, is_u, advance, notice;
   logic [PSW-1:0] pos_step;
   logic [TW-1:0]  top_sum, bot_sum;
   logic [WW-1:0]  x_step;
   cmd_type        cmd;

   // Size writes restart the frame and hold off input while sizes settle.
   assign csr_hit = csr_write_enable &&
                    ((csr_index == REG_FRAME_WIDTH) || (csr_index == REG_FRAME_HEIGHT));

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable && (csr_index == REG_FRAME_WIDTH)) begin
         frame_width_in = csr_write_data;
      end
      if (csr_write_enable && (csr_index == REG_FRAME_HEIGHT)) begin
         frame_height_in = csr_write_data;
      end
   end

   always_comb begin
      settle_in = settle_ff;
      if (csr_hit) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end
   end

   // Effective sizes: limited to the maximum and rounded down to even.
   always_comb begin
      width_c     = WCW'(frame_width_ff);
      width_lim   = WCW'(MAX_WIDTH);
      width_sel   = (width_c < width_lim) ? width_c : width_lim;
      width_trim  = WW'(width_sel);
      eff_w_in    = {width_trim[WW-1:1], 1'b0};
      height_c    = HCW'(frame_height_ff);
      height_lim  = HCW'(MAX_HEIGHT);
      height_sel  = (height_c < height_lim) ? height_c : height_lim;
      height_trim = HW'(height_sel);
      eff_h_in    = {height_trim[HW-1:1], 1'b0};
   end

   // Luma plane size and whole frame size, one register stage each.
   assign luma_n_in = TW'(eff_w_ff) * TW'(eff_h_ff);
   assign total_in  = luma_n_ff + (luma_n_ff >> 1);

   assign req_full = cmd_full || (settle_ff != '0);
   assign accept   = req_push && !req_full;

   // Classify the byte by its position in the frame.
   always_comb begin
      size_zero = (luma_n_ff == '0);
      in_luma   = CW'(pos_ff) < CW'(luma_n_ff);
      in_chroma = !in_luma && (CW'(pos_ff) < CW'(total_ff));
      is_u      = in_chroma && pos_ff[0];
      advance   = in_luma || in_chroma;
      pos_step  = PSW'(pos_ff) + PSW'(advance);
      notice    = req_data.frame_end && !size_zero && (CW'(pos_step) < CW'(total_ff));
      top_sum   = base_ff + TW'(x0_ff);
      bot_sum   = top_sum + TW'(eff_w_ff);
      x_step    = x0_ff + WW'(2);
   end

   // Build the work command for the back part.
   always_comb begin
      cmd.op       = CMD_NONE;
      cmd.notice   = notice;
      cmd.data     = req_data.data_byte;
      cmd.v_byte   = v_latch_ff;
      cmd.x0       = x0_ff;
      cmd.y0       = y0_ff;
      cmd.top_addr = AW'(top_sum);
      cmd.bot_addr = AW'(bot_sum);
      if (in_luma) begin
         cmd.op       = CMD_LUMA;
         cmd.top_addr = AW'(pos_ff);
      end else if (is_u) begin
         cmd.op = CMD_BLOCK;
      end
   end

   assign cmd_push = accept && ((cmd.op != CMD_NONE) || notice);
   assign cmd_data = CMD_W'(cmd);

   // Frame position, V latch and block position counters.
   always_comb begin
      pos_in     = pos_ff;
      v_latch_in = v_latch_ff;
      x0_in      = x0_ff;
      y0_in      = y0_ff;
      base_in    = base_ff;
      if (accept) begin
         if (in_chroma && !pos_ff[0]) begin
            v_latch_in = req_data.data_byte;
         end
         if (is_u) begin
            if (x_step == eff_w_ff) begin
               x0_in   = '0;
               y0_in   = y0_ff + HW'(2);
               base_in = base_ff + (TW'(eff_w_ff) << 1);
            end else begin
               x0_in = x_step;
            end
         end
         pos_in = POS_W'(pos_step);
         if (req_data.frame_end || size_zero) begin
            pos_in  = '0;
            x0_in   = '0;
            y0_in   = '0;
            base_in = '0;
         end
      end
      if (csr_hit) begin
         pos_in  = '0;
         x0_in   = '0;
         y0_in   = '0;
         base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         settle_ff       <= SETTLE_W'(SETTLE_CYCLES);
         pos_ff          <= '0;
         v_latch_ff      <= '0;
         x0_ff           <= '0;
         y0_ff           <= '0;
         base_ff         <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         settle_ff       <= settle_in;
         pos_ff          <= pos_in;
         v_latch_ff      <= v_latch_in;
         x0_ff           <= x0_in;
         y0_ff           <= y0_in;
         base_ff         <= base_in;
      end
   end

   // Derived sizes follow the size registers; the settle count covers them.
   always_ff @(posedge clock) begin
      eff_w_ff  <= eff_w_in;
      eff_h_ff  <= eff_h_in;
      luma_n_ff <= luma_n_in;
      total_ff  <= total_in;
   end

endmodule

>>> hdl/nvc_back.sv
// Back part of the NV21 converter: luma memory, per-pixel sequencer, the
// color conversion pipeline and the result queue. Uses nvc_pkg.
module nvc_back
   import nvc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int WW    = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + 1),
   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
   localparam int CMD_W = $bits(cmd_op_type) + 17 + WW + HW + 2 * AW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  logic [CMD_W-1:0] cmd_data,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   localparam int LUMA_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int OPW        = $clog2(OUT_DEPTH);
   localparam int OCW        = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      cmd_op_type      op;
      logic            notice;
      logic [7:0]      data;
      logic [7:0]      v_byte;
      logic [WW-1:0]   x0;
      logic [HW-1:0]   y0;
      logic [AW-1:0]   top_addr;
      logic [AW-1:0]   bot_addr;
   } cmd_type;

   cmd_type        cmd;
   seq_state_type  seq_ff, seq_in;
   logic [1:0]     pix_ff, pix_in;
   logic           can_issue, mem_we, issue_pix, issue_notice, issue_any;
   logic [AW-1:0]  rd_addr;

   logic [7:0]     luma_mem [LUMA_DEPTH];
   logic [7:0]     luma_rd_ff;

   // Stage one: luma read data plus the pixel's context.
   logic               s1_valid_ff, s1_kind_ff, s1_last_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [7:0]         s1_u_ff, s1_v_ff;

   // Stage two: coefficient products.
   logic                    s2_valid_ff, s2_kind_ff, s2_last_ff;
   logic [COORD_W-1:0]      s2_x_ff, s2_y_ff;
   logic signed [ACC_W-1:0] c298_ff, e409_ff, d100_ff, e208_ff, d516_ff;
   logic signed [ACC_W-1:0] c298_in, e409_in, d100_in, e208_in, d516_in;
   logic signed [9:0]       c_val, d_val, e_val;

   logic signed [ACC_W-1:0] red_acc, green_acc, blue_acc;
   rsp_type                 rsp_in;

   // Result queue with a credit count that covers pixels still in flight.
   rsp_type         out_mem [OUT_DEPTH];
   logic [OPW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OCW-1:0]  count_ff, count_in, credit_ff, credit_in;
   logic            out_pop;

   assign cmd       = cmd_type'(cmd_data);
   assign can_issue = credit_ff < OCW'(OUT_DEPTH);
   assign issue_any = issue_pix || issue_notice;

   // Sequencer outputs: at most one memory access or one result issue per cycle.
   always_comb begin
      mem_we       = 1'b0;
      issue_pix    = 1'b0;
      issue_notice = 1'b0;
      cmd_pop      = 1'b0;
      unique case (seq_ff)
         SEQ_WORK: begin
            if (!cmd_empty) begin
               unique case (cmd.op)
                  CMD_LUMA: begin
                     mem_we  = 1'b1;
                     cmd_pop = !cmd.notice;
                  end
                  CMD_BLOCK: begin
                     if (can_issue) begin
                        issue_pix = 1'b1;
                        cmd_pop   = (pix_ff == 2'd3) && !cmd.notice;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_NOTICE: begin
            if (can_issue) begin
               issue_notice = 1'b1;
               cmd_pop      = 1'b1;
            end
         end
      endcase
   end

   // Sequencer next state: the notice follows the work of its command.
   always_comb begin
      seq_in = seq_ff;
      pix_in = pix_ff;
      unique case (seq_ff)
         SEQ_WORK: begin
            if (!cmd_empty) begin
               unique case (cmd.op)
                  CMD_LUMA: begin
                     if (cmd.notice) begin
                        seq_in = SEQ_NOTICE;
                     end
                  end
                  CMD_BLOCK: begin
                     if (can_issue) begin
                        pix_in = pix_ff + 2'd1;
                        if ((pix_ff == 2'd3) && cmd.notice) begin
                           seq_in = SEQ_NOTICE;
                        end
                     end
                  end
                  default: begin
                     seq_in = SEQ_NOTICE;
                  end
               endcase
            end
         end
         SEQ_NOTICE: begin
            if (can_issue) begin
               seq_in = SEQ_WORK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_WORK;
         pix_ff <= '0;
      end else begin
         seq_ff <= seq_in;
         pix_ff <= pix_in;
      end
   end

   // Luma memory: bottom row for the upper pixel index, right column for odd.
   assign rd_addr = (pix_ff[1] ? cmd.bot_addr : cmd.top_addr) + AW'(pix_ff[0]);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         luma_mem[cmd.top_addr] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_pix) begin
         luma_rd_ff <= luma_mem[rd_addr];
      end
   end

   // Stage one context registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue_any;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_any) begin
         s1_kind_ff <= issue_notice ? RESULT_NOTICE : RESULT_PIXEL;
         s1_last_ff <= issue_notice || ((pix_ff == 2'd3) && !cmd.notice);
         s1_x_ff    <= issue_notice ? '0 : COORD_W'(cmd.x0 + WW'(pix_ff[0]));
         s1_y_ff    <= issue_notice ? '0 : COORD_W'(cmd.y0 + HW'(pix_ff[1]));
         s1_u_ff    <= cmd.data;
         s1_v_ff    <= cmd.v_byte;
      end
   end

   // Stage two: bias removal and the five coefficient products.
   always_comb begin
      c_val   = $signed({2'b00, luma_rd_ff}) - LUMA_BIAS;
      d_val   = $signed({2'b00, s1_u_ff}) - CHROMA_BIAS;
      e_val   = $signed({2'b00, s1_v_ff}) - CHROMA_BIAS;
      c298_in = ACC_W'(c_val) * COEF_Y;
      e409_in = ACC_W'(e_val) * COEF_RV;
      d100_in = ACC_W'(d_val) * COEF_GU;
      e208_in = ACC_W'(e_val) * COEF_GV;
      d516_in = ACC_W'(d_val) * COEF_BU;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_kind_ff <= s1_kind_ff;
         s2_last_ff <= s1_last_ff;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         c298_ff    <= c298_in;
         e409_ff    <= e409_in;
         d100_ff    <= d100_in;
         e208_ff    <= e208_in;
         d516_ff    <= d516_in;
      end
   end

   // Sums with rounding, then shift and clamp into the result item.
   always_comb begin
      red_acc   = c298_ff + e409_ff + ROUND_BIAS;
      green_acc = c298_ff - d100_ff - e208_ff + ROUND_BIAS;
      blue_acc  = c298_ff + d516_ff + ROUND_BIAS;
      rsp_in.result_kind = s2_kind_ff;
      rsp_in.pixel_x     = s2_x_ff;
      rsp_in.pixel_y     = s2_y_ff;
      rsp_in.last_of_run = s2_last_ff;
      if (s2_kind_ff == RESULT_NOTICE) begin
         rsp_in.pixel_red   = '0;
         rsp_in.pixel_green = '0;
         rsp_in.pixel_blue  = '0;
      end else begin
         rsp_in.pixel_red   = clamp_pixel(red_acc);
         rsp_in.pixel_green = clamp_pixel(green_acc);
         rsp_in.pixel_blue  = clamp_pixel(blue_acc);
      end
   end

   // Result queue pointers, fill count and credits.
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = out_mem[rd_ptr_ff];
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      credit_in = credit_ff;
      if (s2_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == OPW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + OPW'(1);
      end
      if (out_pop) begin
         rd_ptr_in = (rd_ptr_ff == OPW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + OPW'(1);
      end
      if (s2_valid_ff && !out_pop) begin
         count_in = count_ff + OCW'(1);
      end else if (out_pop && !s2_valid_ff) begin
         count_in = count_ff - OCW'(1);
      end
      if (issue_any && !out_pop) begin
         credit_in = credit_ff + OCW'(1);
      end else if (out_pop && !issue_any) begin
         credit_in = credit_ff - OCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         out_mem[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

>>> hdl/nv21_to_rgb32_converter.sv
// Top level of the NV21 to RGB32 converter.
// Instantiates nvc_front, nvc_cmd_queue and nvc_back; uses nvc_pkg.
//
// Bytes of an NV21 frame enter on the req_ queue port: the luma plane first,
// then V,U pairs. Each U byte yields the four pixels of its 2x2 block, top
// row first and left first, in BT.601 integer form with implied alpha 0xFF;
// an early frame end adds a short-frame notice (result_kind 1) after them.
// A luma byte occupies the back end with one luma memory write, a V byte not
// at all and a U byte with four pixel issues (one luma memory read and one
// result per cycle while result credits remain); a luma byte can be taken
// every cycle while the command queue has room. A pixel passes the luma read
// and stage one registers, then the stage two registers, then the result
// queue before it reaches rsp_. After reset and after each size write the
// input shows full while the frame sizes are recomputed. The luma memory has
// no clearing pass; only entries of the current frame are read.
module nv21_to_rgb32_converter
   import nvc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int CMD_W = $bits(cmd_op_type) + 17 + WW + HW + 2 * AW;

   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_wr_data, cmd_rd_data;

   // Front part: sizes, frame position and byte classification.
   nvc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wr_data),
      .cmd_full         (cmd_full)
   );

   // Command queue decouples classification from conversion.
   nvc_cmd_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty)
   );

   // Back part: luma memory, conversion pipeline and result queue.
   nvc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
